// ===== rtl/core/sapm_pkg.sv =====
`timescale 1ns / 1ps

package sapm_pkg;

    // Angle fraction bits and the near-zero divisor bound derived from them
    localparam int ANGLE_FRAC_BITS   = 12;
    localparam int NEAR_ZERO_MAX     = ((1 << ANGLE_FRAC_BITS) - 1) / 1000000;

    // Default minimum spacing between emitted words, in ns
    localparam int UPDATE_PERIOD_DEF = 20000000;

    // Field widths
    localparam int ANGLE_W = 16;
    localparam int PULSE_W = 22;
    localparam int TIME_W  = 48;
    localparam int ID_W    = 8;

    // Divider operand widths: |angle * span| < 2^37, |divisor| <= 65535
    localparam int NUM_W = 37;
    localparam int DEN_W = 16;
    localparam int CNT_W = $clog2(NUM_W);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 22;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_CENTER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_OFFSET = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_NUMBER = 3'd7;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic [PULSE_W-1:0]        pulse_t;

endpackage

// ===== rtl/core/sapm_div.sv =====
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle
module sapm_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sapm_pkg::NUM_W-1:0] num,
    input  logic [sapm_pkg::DEN_W-1:0] den,
    output logic [sapm_pkg::NUM_W-1:0] quot,
    output logic                      done
);
    import sapm_pkg::*;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

    logic [NUM_W-1:0] dvd_reg, dvd_next;
    logic [DEN_W-1:0] dsr_reg, dsr_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;

    // Shift in the next dividend bit and trial-subtract the divisor
    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, dsr_reg};
        ge      = (rem_sh >= {1'b0, dsr_reg});
    end

    // Load on start, then step until the last quotient bit
    always_comb
    begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = num;
            dsr_next  = den;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[NUM_W-2:0], ge};
            rem_next = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign quot = dvd_reg;
    assign done = done_reg;

endmodule

// ===== rtl/core/servo_angle_to_pulse_mapper_top.sv =====
`timescale 1ns / 1ps
// The sequencer takes no new input word until the current one has passed the 37-step serial
// divider and its result is in the output register; a word dropped by the update-period check
// leaves the sequencer idle, so the next word can be taken.
// s_axis_tready is high only while the sequencer is idle; a finished result waits in
// the output register while the next word is taken.
// Reset (rst_n, async, active low) loads the register defaults and zeroes the last emit time.
module servo_angle_to_pulse_mapper_top #(
    parameter int UPDATE_PERIOD = sapm_pkg::UPDATE_PERIOD_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [63:0]                    s_axis_tdata,  // [15:0] command_angle, [63:16] now_time
    // Output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,  // [7:0] servo_out_id, [29:8] pulse_width
    // Register write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sapm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sapm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sapm_pkg::*;

    localparam logic [TIME_W-1:0] PERIOD = TIME_W'(UPDATE_PERIOD);
    localparam logic [16:0]       NZ_MAX = 17'(NEAR_ZERO_MAX);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_SEL    = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_DSTART = 3'd4;
    localparam logic [2:0] S_DWAIT  = 3'd5;
    localparam logic [2:0] S_ADD    = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    // Configuration registers
    angle_t          angle_low_reg, angle_high_reg, angle_offset_reg;
    pulse_t          pulse_low_reg, pulse_high_reg, pulse_center_reg;
    logic            reverse_reg;
    logic [ID_W-1:0] servo_number_reg;

    // Control
    logic [2:0]        state_reg, state_next;
    logic [TIME_W-1:0] last_emit_reg;
    logic              out_valid_reg;

    // Datapath
    angle_t              cmd_reg;
    angle_t              angle_reg, angle_next;
    logic signed [22:0]  span_reg, span_next;
    logic [DEN_W-1:0]    den_mag_reg, den_mag_next;
    logic                den_neg_reg, den_neg_next;
    logic                zero_reg, zero_next;
    logic signed [38:0]  prod_reg;
    logic signed [39:0]  sum_reg, sum_next;
    logic [ID_W-1:0]     out_id_reg;
    pulse_t              out_pulse_reg, out_pulse_next;

    logic [ANGLE_W-1:0]  in_cmd;
    logic [TIME_W-1:0]   in_time;
    logic [TIME_W-1:0]   elapsed;
    logic                s_fire, emit, out_load;

    logic                div_start, div_done;
    logic [NUM_W-1:0]    div_num, div_quot;

    logic signed [17:0]  sum18, corr18, lo18, hi18, clamp1;
    logic signed [16:0]  prim17, fall17;
    logic [16:0]         prim_abs, fall_abs;
    logic                a_nonneg;
    logic signed [38:0]  prod_abs;
    logic [37:0]         q_ext, q_signed;
    logic signed [39:0]  pl40, ph40, clamp_lo;

    assign in_cmd  = s_axis_tdata[15:0];
    assign in_time = s_axis_tdata[63:16];

    // Accept only when idle; drop words that arrive inside the update period
    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign elapsed       = in_time - last_emit_reg;
    assign emit          = s_fire && (elapsed >= PERIOD);
    assign cfg_ready     = 1'b1;

    // Apply offset and direction, then clamp to the angle limits
    always_comb
    begin
        lo18   = $signed({{2{angle_low_reg[15]}}, angle_low_reg});
        hi18   = $signed({{2{angle_high_reg[15]}}, angle_high_reg});
        sum18  = $signed({{2{cmd_reg[15]}}, cmd_reg})
               + $signed({{2{angle_offset_reg[15]}}, angle_offset_reg});
        corr18 = reverse_reg ? -sum18 : sum18;
        clamp1 = (corr18 < lo18) ? lo18 : corr18;
        angle_next = (clamp1 > hi18) ? angle_high_reg : clamp1[15:0];
    end

    // Pick divisor and span by angle sign, fall back to the full range near zero
    always_comb
    begin
        a_nonneg = !angle_reg[15];
        prim17   = a_nonneg ? $signed({angle_high_reg[15], angle_high_reg})
                            : -$signed({angle_low_reg[15], angle_low_reg});
        fall17   = $signed({angle_high_reg[15], angle_high_reg})
                 - $signed({angle_low_reg[15], angle_low_reg});
        prim_abs = prim17[16] ? 17'(-prim17) : 17'(prim17);
        fall_abs = fall17[16] ? 17'(-fall17) : 17'(fall17);
        span_next = a_nonneg ? $signed({1'b0, pulse_high_reg}) - $signed({1'b0, pulse_center_reg})
                             : $signed({1'b0, pulse_center_reg}) - $signed({1'b0, pulse_low_reg});
        if (prim_abs > NZ_MAX)
        begin
            den_mag_next = prim_abs[DEN_W-1:0];
            den_neg_next = prim17[16];
            zero_next    = 1'b0;
        end
        else
        begin
            den_mag_next = fall_abs[DEN_W-1:0];
            den_neg_next = fall17[16];
            zero_next    = (fall_abs <= NZ_MAX);
        end
    end

    // Feed the divider with the product magnitude
    assign prod_abs  = prod_reg[38] ? -prod_reg : prod_reg;
    assign div_num   = prod_abs[NUM_W-1:0];
    assign div_start = (state_reg == S_DSTART);

    sapm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_mag_reg),
        .quot  (div_quot),
        .done  (div_done)
    );

    // Restore the quotient sign and add the center pulse
    always_comb
    begin
        q_ext    = {1'b0, div_quot};
        q_signed = (prod_reg[38] ^ den_neg_reg) ? -q_ext : q_ext;
        if (zero_reg)
        begin
            q_signed = '0;
        end
        sum_next = $signed({18'b0, pulse_center_reg}) + $signed({{2{q_signed[37]}}, q_signed});
    end

    // Clamp the pulse to the pulse limits
    always_comb
    begin
        pl40     = $signed({18'b0, pulse_low_reg});
        ph40     = $signed({18'b0, pulse_high_reg});
        clamp_lo = (sum_reg < pl40) ? pl40 : sum_reg;
        out_pulse_next = (clamp_lo > ph40) ? pulse_high_reg : clamp_lo[PULSE_W-1:0];
    end

    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || m_axis_tready);

    // Sequence one word through the single divider
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (emit) state_next = S_PREP;
            S_PREP:   state_next = S_SEL;
            S_SEL:    state_next = S_MUL;
            S_MUL:    state_next = S_DSTART;
            S_DSTART: state_next = S_DWAIT;
            S_DWAIT:  if (div_done) state_next = S_ADD;
            S_ADD:    state_next = S_FIN;
            S_FIN:    if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            last_emit_reg    <= '0;
            out_valid_reg    <= 1'b0;
            angle_low_reg    <= -16'sd6434;
            angle_high_reg   <= 16'sd6434;
            pulse_low_reg    <= 22'd500000;
            pulse_high_reg   <= 22'd2500000;
            pulse_center_reg <= 22'd1500000;
            reverse_reg      <= 1'b0;
            angle_offset_reg <= '0;
            servo_number_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                last_emit_reg <= in_time;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ANGLE_LOW:    angle_low_reg    <= cfg_data[15:0];
                    REG_ANGLE_HIGH:   angle_high_reg   <= cfg_data[15:0];
                    REG_PULSE_LOW:    pulse_low_reg    <= cfg_data[PULSE_W-1:0];
                    REG_PULSE_HIGH:   pulse_high_reg   <= cfg_data[PULSE_W-1:0];
                    REG_PULSE_CENTER: pulse_center_reg <= cfg_data[PULSE_W-1:0];
                    REG_REVERSE:      reverse_reg      <= cfg_data[0];
                    REG_ANGLE_OFFSET: angle_offset_reg <= cfg_data[15:0];
                    REG_SERVO_NUMBER: servo_number_reg <= cfg_data[ID_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // Datapath registers, each group loaded in its own step
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            cmd_reg <= in_cmd;
        end
        if (state_reg == S_PREP)
        begin
            angle_reg <= angle_next;
        end
        if (state_reg == S_SEL)
        begin
            span_reg    <= span_next;
            den_mag_reg <= den_mag_next;
            den_neg_reg <= den_neg_next;
            zero_reg    <= zero_next;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= angle_reg * span_reg;
        end
        if (state_reg == S_ADD)
        begin
            sum_reg <= sum_next;
        end
        if (out_load)
        begin
            out_id_reg    <= servo_number_reg;
            out_pulse_reg <= out_pulse_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_pulse_reg, out_id_reg};

    // A word inside the update period leaves the sequencer idle
    a_drop_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && !emit |=> state_reg == S_IDLE)
        else $error("dropped word started the sequencer");

    // The divider finishes only while the sequencer waits for it
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DWAIT)
        else $error("divider done outside wait step");

    // A new result appears only from the final step
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == S_FIN)
        else $error("output loaded outside final step");

    // The last emit time moves only on an accepted word
    a_last_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_fire |=> $stable(last_emit_reg))
        else $error("last emit time changed without input");

endmodule
